// ===== src/eafr_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder angle frame reader package
// Shared codes, widths, the result record and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package eafr_pkg;

    // Frame layout: angle high, angle low, status, then the CRC byte.
    localparam int PAYLOAD_BYTES = 3;
    localparam int POS_W         = 2;

    // CRC-8 with polynomial 0x1D, seeded with all ones, inverted at the end.
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Register reset values.
    localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd6;
    localparam logic [7:0] COMMAND_CODE_RST = 8'h05;
    localparam logic [3:0] ATTEMPT_SAT      = 4'd15;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // Stream payload widths.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_ATTEMPTS = 1'd0,
        REG_COMMAND_CODE = 1'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        EV_COMMAND = 2'd0,
        EV_SUCCESS = 2'd1,
        EV_FAILED  = 2'd2
    } event_t;

    // One result record as produced by the frame logic.
    typedef struct packed {
        event_t       event_res;
        logic [7:0]   tx_byte;
        logic [15:0]  angle;
        logic [7:0]   status;
        logic [7:0]   frame_crc;
        logic [3:0]   attempts_used;
    } result_t;

    // Bitwise CRC-8 update over one byte, most significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== src/eafr_frame.sv =====
// ----------------------------------------------------------------------------
// Encoder angle frame state
// Holds the read state, assembles frames, checks the CRC and forms results.
// ----------------------------------------------------------------------------
module eafr_frame
    import eafr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [3:0]  max_attempts,
    input  logic [7:0]  command_code,
    input  logic        item_valid,
    input  logic        item_fire,
    input  logic [1:0]  item_kind,
    input  logic [7:0]  item_byte,
    output logic        res_valid,
    output result_t     res
);

    logic             busy_reg,      busy_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [7:0]       crc_reg,       crc_next;
    logic [3:0]       attempts_reg,  attempts_next;
    logic [7:0]       ang_hi_reg,    ang_hi_next;
    logic [7:0]       ang_lo_reg,    ang_lo_next;
    logic [7:0]       status_reg,    status_next;

    logic [3:0] limit;
    logic [3:0] attempts_inc;

    assign limit        = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
    assign attempts_inc = (attempts_reg == ATTEMPT_SAT) ? attempts_reg
                                                        : attempts_reg + 4'd1;

    // Next state and result for the item held in the input register.
    always_comb begin
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        attempts_next = attempts_reg;
        ang_hi_next   = ang_hi_reg;
        ang_lo_next   = ang_lo_reg;
        status_next   = status_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.event_res = EV_COMMAND;

        case (item_kind)
            KIND_START: begin
                busy_next     = 1'b1;
                pos_next      = '0;
                crc_next      = CRC_INIT;
                attempts_next = '0;
                res_valid     = 1'b1;
                res.event_res = EV_COMMAND;
                res.tx_byte   = command_code;
            end
            KIND_ABORT: begin
                if (busy_reg) begin
                    busy_next         = 1'b0;
                    pos_next          = '0;
                    crc_next          = CRC_INIT;
                    res_valid         = 1'b1;
                    res.event_res     = EV_FAILED;
                    res.attempts_used = attempts_reg;
                end
            end
            KIND_BYTE: begin
                if (busy_reg) begin
                    if (pos_reg < POS_W'(PAYLOAD_BYTES)) begin
                        // Payload byte: store it and fold it into the CRC.
                        if (pos_reg == 2'd0) begin
                            ang_hi_next = item_byte;
                        end else if (pos_reg == 2'd1) begin
                            ang_lo_next = item_byte;
                        end else begin
                            status_next = item_byte;
                        end
                        crc_next = crc8_update(crc_reg, item_byte);
                        pos_next = pos_reg + 2'd1;
                    end else begin
                        // CRC byte closes the frame.
                        attempts_next = attempts_inc;
                        pos_next      = '0;
                        crc_next      = CRC_INIT;
                        if (item_byte == ~crc_reg) begin
                            busy_next         = 1'b0;
                            res_valid         = 1'b1;
                            res.event_res     = EV_SUCCESS;
                            res.angle         = {ang_hi_reg, ang_lo_reg};
                            res.status        = status_reg;
                            res.frame_crc     = item_byte;
                            res.attempts_used = attempts_inc;
                        end else if (attempts_inc >= limit) begin
                            busy_next         = 1'b0;
                            res_valid         = 1'b1;
                            res.event_res     = EV_FAILED;
                            res.attempts_used = attempts_inc;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (!item_valid) begin
            res_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            attempts_reg <= '0;
        end else if (item_fire) begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            attempts_reg <= attempts_next;
        end
    end

    // Frame payload bytes; only read after the matching position wrote them.
    always_ff @(posedge aclk) begin
        if (item_fire) begin
            ang_hi_reg <= ang_hi_next;
            ang_lo_reg <= ang_lo_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== src/encoder_angle_frame_reader_unit.sv =====
// ----------------------------------------------------------------------------
// Encoder angle frame reader
// Reads CRC-checked angle frames from a serial angle encoder.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per transfer: s_tuser holds the kind
// (start read, received byte, bus error) and s_tdata the received byte.
// A start request yields a command result holding the byte to transmit.
// Received bytes are grouped in frames of angle high, angle low, status and
// CRC; a good frame yields a success result with angle, status and CRC, and
// a bad frame starts another attempt until max_attempts frames have failed.
// A bus error during a read yields a failure result.
// A request passes through one input register and then one result register
// on its way to m_tvalid. One request is accepted every cycle while the
// receiver keeps up; the CRC-8 update of one byte fits between them.
// When the receiver stalls, the result register holds its result and the
// input register still takes one more request; a request that produces no
// result passes through even while the result waits.
// Reset is synchronous and active low; it clears the read state and loads
// the register defaults (six attempts, command byte 0x05).
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata.
// ----------------------------------------------------------------------------
module encoder_angle_frame_reader_unit
    import eafr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] kind
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] tx_byte, [23:8] angle,
                                             // [31:24] status, [39:32] frame_crc,
                                             // [43:40] attempts_used, [47:44] zero
    output logic [M_TUSER_W-1:0]  m_tuser    // [1:0] event_res
);

    logic [3:0] max_attempts_reg;
    logic [7:0] command_code_reg;

    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [7:0] in_byte_reg;

    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       res_valid;
    result_t    res;
    logic       out_free;
    logic       advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            command_code_reg <= COMMAND_CODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_wdata[3:0];
                REG_COMMAND_CODE: command_code_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The held request moves on when it has no result or the result slot frees.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    eafr_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_attempts (max_attempts_reg),
        .command_code (command_code_reg),
        .item_valid   (in_valid_reg),
        .item_fire    (advance),
        .item_kind    (in_kind_reg),
        .item_byte    (in_byte_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {4'd0, out_res_reg.attempts_used, out_res_reg.frame_crc,
                       out_res_reg.status, out_res_reg.angle, out_res_reg.tx_byte};

endmodule

// ===== src/eafr_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder angle frame reader port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module eafr_checker
    import eafr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A command result carries only the command byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_COMMAND) |-> m_tdata[47:8] == 40'd0)
        else $error("command result carries frame fields");

    // A success result has at least one frame counted and no command byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_SUCCESS) |->
            (m_tdata[43:40] != 4'd0) && (m_tdata[7:0] == 8'd0))
        else $error("success result malformed");

endmodule

bind encoder_angle_frame_reader_unit eafr_checker u_eafr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
